// File: rtl/core/sem_pkg.sv
// Shared types and constants of the Sobel edge magnitude block.
package sem_pkg;

  localparam int MAG_BITS       = 19;
  localparam int ROW_BITS       = 16;
  localparam int WIDTH_REG_BITS = 11;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [MAG_BITS-1:0]       MAG_MAX          = '1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GRAD,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_SEND0,
    ST_SEND1,
    ST_SEND2
  } sem_state_t;

  typedef enum logic [1:0] {
    SEL_CENTRE,
    SEL_ROW_END,
    SEL_LAST_ROW
  } sem_sel_t;

  typedef struct packed {
    logic     accept;
    logic     update;
    logic     grad;
    logic     square;
    logic     sum;
    logic     root_step;
    sem_sel_t sel;
  } sem_cmd_t;

  typedef struct packed {
    logic res_centre;
    logic res_row_end;
    logic res_last_row;
    logic needs_mag;
    logic root_done;
  } sem_status_t;

endpackage

// File: rtl/core/sem_ifaces.sv
// Channel interfaces: pixel input, result output and configuration write.
interface sem_pixel_if #(parameter int PIXEL_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_real;
  logic signed [PIXEL_BITS-1:0] pixel_imag;
  modport source (output valid, pixel_real, pixel_imag, input ready);
  modport sink (input valid, pixel_real, pixel_imag, output ready);
endinterface

interface sem_result_if #(parameter int COL_BITS = 10);
  logic                              valid;
  logic                              ready;
  logic [sem_pkg::MAG_BITS-1:0]      edge_magnitude;
  logic [COL_BITS-1:0]               out_column;
  logic [sem_pkg::ROW_BITS-1:0]      out_row;
  logic                              frame_done;
  modport source (output valid, edge_magnitude, out_column, out_row, frame_done,
                  input ready);
  modport sink (input valid, edge_magnitude, out_column, out_row, frame_done,
                output ready);
endinterface

interface sem_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sem_pkg::CFG_INDEX_BITS-1:0] index;
  logic [sem_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/sem_ram.sv
// Generic simple dual-port RAM with registered read.
module sem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/sem_controller.sv
// Sequencing state machine for one pixel transaction.
module sem_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sem_pkg::sem_status_t status,
  output sem_pkg::sem_cmd_t    cmd
);
  import sem_pkg::*;

  sem_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_FETCH;
      ST_FETCH:  state_next = status.needs_mag ? ST_GRAD : ST_SEND0;
      ST_GRAD:   state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (status.root_done) state_next = ST_SEND0;
      ST_SEND0:  if (!status.res_centre || out_ready) state_next = ST_SEND1;
      ST_SEND1:  if (!status.res_row_end || out_ready) state_next = ST_SEND2;
      ST_SEND2:  if (!status.res_last_row || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_CENTRE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_FETCH:  cmd.update    = 1'b1;
      ST_GRAD:   cmd.grad      = 1'b1;
      ST_SQUARE: cmd.square    = 1'b1;
      ST_SUM:    cmd.sum       = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_SEND0: begin
        cmd.sel   = SEL_CENTRE;
        out_valid = status.res_centre;
      end
      ST_SEND1: begin
        cmd.sel   = SEL_ROW_END;
        out_valid = status.res_row_end;
      end
      ST_SEND2: begin
        cmd.sel   = SEL_LAST_ROW;
        out_valid = status.res_last_row;
      end
      default: ;
    endcase
  end
endmodule

// File: rtl/core/sem_datapath.sv
// Counters, line stores, window, gradient, squares and bit-serial square root.
module sem_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sem_pkg::sem_cmd_t                     cmd,
  output sem_pkg::sem_status_t                  status,
  input  logic                                  cfg_we,
  input  logic [sem_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic signed [PIXEL_BITS-1:0]          pixel_real,
  input  logic signed [PIXEL_BITS-1:0]          pixel_imag,
  output logic [sem_pkg::MAG_BITS-1:0]          edge_magnitude,
  output logic [$clog2(MAX_WIDTH)-1:0]          out_column,
  output logic [sem_pkg::ROW_BITS-1:0]          out_row,
  output logic                                  frame_done
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int P  = PIXEL_BITS;
  localparam int GB = P + 3;
  localparam int AB = P + 2;
  localparam int QB = 2 * AB;
  localparam int SB = QB + 2;
  localparam int RB = SB / 2;
  localparam int NB = $clog2(RB);

  logic [WIDTH_REG_BITS-1:0] frame_width;
  logic [ROW_BITS-1:0]       frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_REG_BITS'(640);
      frame_height <= ROW_BITS'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW:0]         w_eff;
  logic [CW-1:0]       wlast, col_cnt, c_now;
  logic [ROW_BITS-1:0] h_eff, hlast, row_cnt;
  logic                last_col, last_row, centre, border;

  always_comb begin
    if (frame_width < WIDTH_REG_BITS'(3)) begin
      w_eff = (CW+1)'(3);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(frame_width);
    end
    wlast    = CW'(w_eff - 1'b1);
    h_eff    = (frame_height < ROW_BITS'(3)) ? ROW_BITS'(3) : frame_height;
    hlast    = h_eff - 1'b1;
    c_now    = ({1'b0, col_cnt} >= w_eff) ? wlast : col_cnt;
    last_col = c_now >= wlast;
    last_row = row_cnt >= hlast;
    centre   = (c_now != '0) && (row_cnt != '0);
    border   = (c_now == CW'(1)) || (row_cnt == ROW_BITS'(1)) ||
               ((c_now - 1'b1) >= wlast) || ((row_cnt - 1'b1) >= hlast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cmd.accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= c_now + 1'b1;
      end
    end
  end

  logic signed [P-1:0] px_re, px_im;
  logic [CW-1:0]       cur_c, cur_wlast;
  logic [ROW_BITS-1:0] cur_r;
  logic                cur_last_col, cur_centre, cur_row_end, cur_last_row, cur_mag;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_re        <= pixel_real;
      px_im        <= pixel_imag;
      cur_c        <= c_now;
      cur_r        <= row_cnt;
      cur_wlast    <= wlast;
      cur_last_col <= last_col;
      cur_centre   <= centre;
      cur_row_end  <= last_col && (row_cnt != '0);
      cur_last_row <= last_row;
      cur_mag      <= centre && !border;
    end
  end

  logic [2*P-1:0] upper_rdata, middle_rdata;

  sem_ram #(.WIDTH(2*P), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (cur_c),
    .wdata (middle_rdata),
    .raddr (c_now),
    .rdata (upper_rdata)
  );

  sem_ram #(.WIDTH(2*P), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (cur_c),
    .wdata ({px_re, px_im}),
    .raddr (c_now),
    .rdata (middle_rdata)
  );

  logic signed [P-1:0] win_re [3][3];
  logic signed [P-1:0] win_im [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_re[i][j] <= '0;
          win_im[i][j] <= '0;
        end
      end
    end else if (cmd.update) begin
      for (int i = 0; i < 3; i++) begin
        win_re[i][0] <= win_re[i][1];
        win_re[i][1] <= win_re[i][2];
        win_im[i][0] <= win_im[i][1];
        win_im[i][1] <= win_im[i][2];
      end
      win_re[0][2] <= upper_rdata[2*P-1:P];
      win_im[0][2] <= upper_rdata[P-1:0];
      win_re[1][2] <= middle_rdata[2*P-1:P];
      win_im[1][2] <= middle_rdata[P-1:0];
      win_re[2][2] <= px_re;
      win_im[2][2] <= px_im;
    end
  end

  logic signed [GB-1:0] gxr, gxi, gyr, gyi;
  logic signed [GB-1:0] gxr_q, gxi_q, gyr_q, gyi_q;

  always_comb begin
    gxr = (GB'(win_re[0][2]) + (GB'(win_re[1][2]) <<< 1) + GB'(win_re[2][2]))
        - (GB'(win_re[0][0]) + (GB'(win_re[1][0]) <<< 1) + GB'(win_re[2][0]));
    gxi = (GB'(win_im[0][2]) + (GB'(win_im[1][2]) <<< 1) + GB'(win_im[2][2]))
        - (GB'(win_im[0][0]) + (GB'(win_im[1][0]) <<< 1) + GB'(win_im[2][0]));
    gyr = (GB'(win_re[2][0]) + (GB'(win_re[2][1]) <<< 1) + GB'(win_re[2][2]))
        - (GB'(win_re[0][0]) + (GB'(win_re[0][1]) <<< 1) + GB'(win_re[0][2]));
    gyi = (GB'(win_im[2][0]) + (GB'(win_im[2][1]) <<< 1) + GB'(win_im[2][2]))
        - (GB'(win_im[0][0]) + (GB'(win_im[0][1]) <<< 1) + GB'(win_im[0][2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gxr_q <= gxr;
      gxi_q <= gxi;
      gyr_q <= gyr;
      gyi_q <= gyi;
    end
  end

  logic [GB-1:0] n_xr, n_xi, n_yr, n_yi;
  logic [AB-1:0] a_xr, a_xi, a_yr, a_yi;
  logic [QB-1:0] sq_xr, sq_xi, sq_yr, sq_yi;

  always_comb begin
    n_xr = gxr_q[GB-1] ? -gxr_q : gxr_q;
    n_xi = gxi_q[GB-1] ? -gxi_q : gxi_q;
    n_yr = gyr_q[GB-1] ? -gyr_q : gyr_q;
    n_yi = gyi_q[GB-1] ? -gyi_q : gyi_q;
    a_xr = n_xr[AB-1:0];
    a_xi = n_xi[AB-1:0];
    a_yr = n_yr[AB-1:0];
    a_yi = n_yi[AB-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_xr <= a_xr * a_xr;
      sq_xi <= a_xi * a_xi;
      sq_yr <= a_yr * a_yr;
      sq_yi <= a_yi * a_yi;
    end
  end

  logic [SB-1:0]   rad;
  logic [RB+1:0]   rem, rem_t, trial;
  logic [RB-1:0]   root;
  logic [NB-1:0]   iter;

  always_comb begin
    rem_t = {rem[RB-1:0], rad[SB-1:SB-2]};
    trial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rad  <= SB'(sq_xr) + SB'(sq_xi) + SB'(sq_yr) + SB'(sq_yi);
      rem  <= '0;
      root <= '0;
      iter <= NB'(RB - 1);
    end else if (cmd.root_step) begin
      if (rem_t >= trial) begin
        rem  <= rem_t - trial;
        root <= {root[RB-2:0], 1'b1};
      end else begin
        rem  <= rem_t;
        root <= {root[RB-2:0], 1'b0};
      end
      rad  <= rad << 2;
      iter <= iter - 1'b1;
    end
  end

  logic [MAG_BITS-1:0] mag;

  always_comb begin
    if (!cur_mag) begin
      mag = '0;
    end else if (32'(root) > 32'(MAG_MAX)) begin
      mag = MAG_MAX;
    end else begin
      mag = MAG_BITS'(root);
    end
  end

  always_comb begin
    status.res_centre   = cur_centre;
    status.res_row_end  = cur_row_end;
    status.res_last_row = cur_last_row;
    status.needs_mag    = cur_mag;
    status.root_done    = (iter == '0);
  end

  always_comb begin
    case (cmd.sel)
      SEL_CENTRE: begin
        edge_magnitude = mag;
        out_column     = cur_c - 1'b1;
        out_row        = cur_r - 1'b1;
        frame_done     = 1'b0;
      end
      SEL_ROW_END: begin
        edge_magnitude = '0;
        out_column     = cur_wlast;
        out_row        = cur_r - 1'b1;
        frame_done     = 1'b0;
      end
      SEL_LAST_ROW: begin
        edge_magnitude = '0;
        out_column     = cur_c;
        out_row        = cur_r;
        frame_done     = cur_last_col;
      end
      default: begin
        edge_magnitude = '0;
        out_column     = '0;
        out_row        = '0;
        frame_done     = 1'b0;
      end
    endcase
  end
endmodule

// File: rtl/core/sobel_edge_magnitude.sv
// Top level of the Sobel edge magnitude block.
//
//  channel  | direction | transaction
//  pix_in   | sink      | one complex pixel, raster order
//  res_out  | source    | magnitude, column, row, frame_done
//  cfg      | sink      | register index and write data
//
// A pixel that needs no magnitude passes through accept, fetch and three result
// slots, each taken whether or not it carries a result; an interior centre adds
// the gradient, squares, sum and the one-bit-per-cycle square root.
// Reset clears the counters and the window and sets the configuration registers
// to width 640 and height 480; line stores are not cleared.
// A stalled result holds the pixel side until it is taken.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  sem_pixel_if.sink   pix_in,
  sem_result_if.source res_out,
  sem_cfg_if.sink     cfg
);
  import sem_pkg::*;

  sem_cmd_t    cmd;
  sem_status_t status;

  assign cfg.ready = 1'b1;

  sem_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .pixel_real     (pix_in.pixel_real),
    .pixel_imag     (pix_in.pixel_imag),
    .edge_magnitude (res_out.edge_magnitude),
    .out_column     (res_out.out_column),
    .out_row        (res_out.out_row),
    .frame_done     (res_out.frame_done)
  );
endmodule

// File: rtl/core/sem_checker.sv
// Port-level checks of the Sobel edge magnitude block, bound to its top level.
module sem_checker #(
  parameter int COL_BITS = 10
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sem_pkg::MAG_BITS-1:0] edge_magnitude,
  input logic [COL_BITS-1:0]          out_column,
  input logic [sem_pkg::ROW_BITS-1:0] out_row,
  input logic                         frame_done
);
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready)) else $error("result offered while taking pixels");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result right after pixel");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> (edge_magnitude == '0))
    else $error("frame end with nonzero magnitude");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_column == '0 || out_row == '0)) |-> (edge_magnitude == '0))
    else $error("border result nonzero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind sobel_edge_magnitude sem_checker #(.COL_BITS($clog2(MAX_WIDTH))) u_sem_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (pix_in.valid),
  .in_ready       (pix_in.ready),
  .out_valid      (res_out.valid),
  .out_ready      (res_out.ready),
  .edge_magnitude (res_out.edge_magnitude),
  .out_column     (res_out.out_column),
  .out_row        (res_out.out_row),
  .frame_done     (res_out.frame_done)
);

// File: test/tb.sv
// Self-checking testbench for the Sobel edge magnitude block.
module tb;
  import sem_pkg::*;

  localparam int LINE_DEPTH   = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam logic signed [15:0] PIX_MIN = -16'sd32768;
  localparam logic signed [15:0] PIX_MAX = 16'sd32767;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } cpx_t;

  typedef struct {
    logic [MAG_BITS-1:0] mag;
    logic [9:0]          col;
    logic [ROW_BITS-1:0] row;
    logic                done;
  } edge_result_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    int                 want_mag;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  sem_pixel_if  pix ();
  sem_result_if res ();
  sem_cfg_if    cfg_ch ();

  sobel_edge_magnitude u_dut (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix.sink),
    .res_out(res.source),
    .cfg    (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpx_t         upper_line [LINE_DEPTH];
  cpx_t         middle_line [LINE_DEPTH];
  cpx_t         win [3][3];
  int unsigned  col_cnt;
  int unsigned  row_cnt;
  logic [10:0]  width_reg;
  logic [15:0]  height_reg;
  edge_result_t pending_q[$];

  int  idle_pct;
  int  stall_pct;
  bit  failed;
  int  quiet_cycles;

  stim_row_t directed [18] = '{
    '{PIX_MIN, PIX_MAX, -1}, '{PIX_MIN, PIX_MAX, -1}, '{PIX_MIN, PIX_MAX, -1},
    '{PIX_MIN, PIX_MAX, -1}, '{PIX_MIN, PIX_MAX, -1}, '{PIX_MIN, PIX_MAX, -1},
    '{PIX_MIN, PIX_MAX, -1}, '{PIX_MIN, PIX_MAX, -1}, '{PIX_MIN, PIX_MAX, 0},
    '{PIX_MIN, 16'sd0, -1}, '{16'sd0, 16'sd0, -1}, '{PIX_MAX, 16'sd0, -1},
    '{PIX_MIN, 16'sd0, -1}, '{16'sd0, 16'sd0, -1}, '{PIX_MAX, 16'sd0, -1},
    '{PIX_MIN, 16'sd0, -1}, '{16'sd0, 16'sd0, -1}, '{PIX_MAX, 16'sd0, 262140}
  };

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned acc;
    longint unsigned bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v   -= acc + bitv;
        acc  = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic logic [MAG_BITS-1:0] gradient_magnitude();
    longint gxr, gxi, gyr, gyi;
    longint unsigned m;
    gxr = (win[0][2].re + 2 * win[1][2].re + win[2][2].re)
        - (win[0][0].re + 2 * win[1][0].re + win[2][0].re);
    gxi = (win[0][2].im + 2 * win[1][2].im + win[2][2].im)
        - (win[0][0].im + 2 * win[1][0].im + win[2][0].im);
    gyr = (win[2][0].re + 2 * win[2][1].re + win[2][2].re)
        - (win[0][0].re + 2 * win[0][1].re + win[0][2].re);
    gyi = (win[2][0].im + 2 * win[2][1].im + win[2][2].im)
        - (win[0][0].im + 2 * win[0][1].im + win[0][2].im);
    m = floor_root(gxr * gxr + gxi * gxi + gyr * gyr + gyi * gyi);
    return (m > MAG_MAX) ? MAG_MAX : m[MAG_BITS-1:0];
  endfunction

  function automatic void add_result(logic [MAG_BITS-1:0] mag, int unsigned c,
                                     int unsigned r, logic done);
    edge_result_t e;
    e.mag  = mag;
    e.col  = c[9:0];
    e.row  = r[ROW_BITS-1:0];
    e.done = done;
    pending_q.push_back(e);
  endfunction

  function automatic void predict_pixel(cpx_t px);
    int unsigned w, h, c, r;
    bit lc, lr, border;
    w = eff_width();
    h = eff_height();
    if (col_cnt >= w) col_cnt = w - 1;
    c  = col_cnt;
    r  = row_cnt;
    lc = (c >= w - 1);
    lr = (r >= h - 1);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]      = upper_line[c];
    win[1][2]      = middle_line[c];
    win[2][2]      = px;
    upper_line[c]  = middle_line[c];
    middle_line[c] = px;
    if (c >= 1 && r >= 1) begin
      border = (c - 1 == 0) || (r - 1 == 0) || (c - 1 >= w - 1) || (r - 1 >= h - 1);
      add_result(border ? '0 : gradient_magnitude(), c - 1, r - 1, 1'b0);
    end
    if (lc && r >= 1) add_result('0, w - 1, r - 1, 1'b0);
    if (lr) add_result('0, c, r, lc);
    if (lc) begin
      col_cnt = 0;
      row_cnt = lr ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  task automatic send_pixel(cpx_t px, int want_mag);
    int first;
    if ($urandom_range(0, 99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.pixel_real <= px.re;
    pix.pixel_imag <= px.im;
    do @(negedge clk); while (!pix.ready);
    @(posedge clk);
    first = pending_q.size();
    predict_pixel(px);
    if (want_mag >= 0) pending_q[first].mag = MAG_BITS'(want_mag);
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
    else height_reg = val;
  endtask

  function automatic cpx_t random_pixel();
    cpx_t p;
    case ($urandom_range(0, 5))
      0:       p.re = PIX_MIN;
      1:       p.re = PIX_MAX;
      default: p.re = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       p.im = PIX_MIN;
      1:       p.im = PIX_MAX;
      default: p.im = 16'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(random_pixel(), -1);
  endtask

  always @(posedge clk) begin
    res.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  always @(negedge clk) begin
    edge_result_t e;
    if (!rst && res.valid && res.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result col %0d row %0d", res.out_column, res.out_row);
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (res.edge_magnitude !== e.mag) begin
          $error("edge_magnitude: expected %0d, got %0d", e.mag, res.edge_magnitude);
          failed = 1'b1;
        end
        if (res.out_column !== e.col) begin
          $error("out_column: expected %0d, got %0d", e.col, res.out_column);
          failed = 1'b1;
        end
        if (res.out_row !== e.row) begin
          $error("out_row: expected %0d, got %0d", e.row, res.out_row);
          failed = 1'b1;
        end
        if (res.frame_done !== e.done) begin
          $error("frame_done: expected %0d, got %0d", e.done, res.frame_done);
          failed = 1'b1;
        end
      end
    end
    if ((pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  int w_regs [7] = '{4, 0, 5, 16'hF804, 4, 5, 3};
  int h_regs [7] = '{4, 1, 3, 2, 3, 3, 65535};

  initial begin
    cpx_t p;
    rst            = 1'b1;
    pix.valid      = 1'b0;
    pix.pixel_real = '0;
    pix.pixel_imag = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_FRAME_WIDTH;
    cfg_ch.data    = '0;
    res.ready      = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    failed         = 1'b0;
    quiet_cycles   = 0;
    width_reg      = 11'd640;
    height_reg     = 16'd480;
    col_cnt        = 0;
    row_cnt        = 0;
    foreach (win[i, j]) win[i][j] = '{16'sd0, 16'sd0};
    foreach (upper_line[i]) begin
      upper_line[i]  = '{16'sd0, 16'sd0};
      middle_line[i] = '{16'sd0, 16'sd0};
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    foreach (directed[i]) begin
      p.re = directed[i].re;
      p.im = directed[i].im;
      send_pixel(p, directed[i].want_mag);
    end
    drain();

    for (int f = 0; f < 7; f++) begin
      case (f % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      write_reg(REG_FRAME_WIDTH, 16'(w_regs[f]));
      write_reg(REG_FRAME_HEIGHT, 16'(h_regs[f]));
      if (h_regs[f] == 65535) begin
        // shrink the height mid-frame, past the current row
        send_pixels(eff_width() * 3);
        drain();
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        send_pixels(eff_width() + eff_width() * 3);
      end else begin
        send_pixels(eff_width() * eff_height());
      end
      drain();
    end

    if (!failed) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sem_pkg.sv
rtl/core/sem_ifaces.sv
rtl/core/sem_ram.sv
rtl/core/sem_controller.sv
rtl/core/sem_datapath.sv
rtl/core/sobel_edge_magnitude.sv
rtl/core/sem_checker.sv
test/tb.sv
